// ===== src/pid_pkg.sv =====
// Shared types, constants and width helpers for the PID controller step block.
// Used by pid_ctrl, pid_dp and pid_controller_step; depends on nothing else.
package pid_pkg;

	// Default parameter values.
	localparam int SAMPLE_BITS_DEF = 10;
	localparam int FRAC_BITS_DEF   = 16;

	// Fixed field and register widths.
	localparam int GAIN_W      = 24;
	localparam int STEP_W      = 16;
	localparam int DEN_W       = 17;
	localparam int INTEG_W     = 48;
	localparam int DRIVE_W     = 32;
	localparam int CHUNK_W     = 24;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	// Time-unit divisors: milliseconds and the finer unit.
	localparam int DIV_MS    = 1000;
	localparam int DIV_OTHER = 100000;

	// Reset values of the gains and the time base.
	localparam logic signed [GAIN_W-1:0] GAIN_P_RESET = 24'sd65536;
	localparam logic [STEP_W-1:0]        STEP_RESET   = 16'd10;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_REFERENCE = 3'd0,
		REG_GAIN_P    = 3'd1,
		REG_GAIN_I    = 3'd2,
		REG_GAIN_D    = 3'd3,
		REG_TIME_STEP = 3'd4,
		REG_TIME_UNIT = 3'd5
	} reg_idx_t;

	// Which gain term the multiply-accumulate is working on.
	typedef enum logic [1:0] {
		TERM_P = 2'd0,
		TERM_I = 2'd1,
		TERM_D = 2'd2
	} term_t;

	// Sequencer states, one-hot.
	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_LOAD_I = 12'b0000_0000_0010,
		S_DIV_I  = 12'b0000_0000_0100,
		S_INT    = 12'b0000_0000_1000,
		S_LOAD_D = 12'b0000_0001_0000,
		S_DIV_D  = 12'b0000_0010_0000,
		S_DER    = 12'b0000_0100_0000,
		S_OPND   = 12'b0000_1000_0000,
		S_MUL    = 12'b0001_0000_0000,
		S_ACC    = 12'b0010_0000_0000,
		S_FOLD   = 12'b0100_0000_0000,
		S_DONE   = 12'b1000_0000_0000
	} state_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic  take;
		logic  div_load_i;
		logic  div_load_d;
		logic  div_step;
		logic  int_update;
		logic  deriv_update;
		logic  op_load;
		term_t term;
		logic  mul;
		logic  top_chunk;
		logic  acc_add;
		logic  fold;
		logic  out_load;
	} pid_cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic ts_zero;
		logic out_free;
	} pid_stat_t;

	// Number of two-bit divider steps for the widest dividend.
	function automatic int div_iters(int sample_bits, int frac_bits);
		return (sample_bits + frac_bits + 20) / 2;
	endfunction

	// Width of the signed operands (integral and derivative) fed to the gains.
	function automatic int opnd_bits(int sample_bits, int frac_bits);
		int nb;
		nb = 2 * div_iters(sample_bits, frac_bits);
		return (nb + 1 > INTEG_W) ? nb + 1 : INTEG_W;
	endfunction

	// Number of multiplier chunks per gain product.
	function automatic int chunk_count(int sample_bits, int frac_bits);
		return (opnd_bits(sample_bits, frac_bits) + CHUNK_W - 1) / CHUNK_W;
	endfunction

endpackage

// ===== src/pid_ctrl.sv =====
// Sequencer for the PID controller step: one-hot state machine and loop counters.
// Depends on pid_pkg for the state, command and status types.
module pid_ctrl #(
	parameter int SAMPLE_BITS = pid_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = pid_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pid_pkg::pid_stat_t  stat,
	output pid_pkg::pid_cmd_t   cmd
);

	localparam int ITERS = pid_pkg::div_iters(SAMPLE_BITS, FRAC_BITS);
	localparam int NCH   = pid_pkg::chunk_count(SAMPLE_BITS, FRAC_BITS);
	localparam int CNT_W = $clog2(ITERS);
	localparam int CHK_W = $clog2(NCH);

	pid_pkg::state_t state_q, state_d;
	pid_pkg::term_t  term_q, term_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CHK_W-1:0] chk_q, chk_d;
	pid_pkg::term_t  term_next;

	// Order of the gain terms.
	always_comb begin
		unique case (term_q)
			pid_pkg::TERM_P: term_next = pid_pkg::TERM_I;
			pid_pkg::TERM_I: term_next = pid_pkg::TERM_D;
			default:         term_next = pid_pkg::TERM_P;
		endcase
	end

	// Next-state and command decode.
	always_comb begin
		state_d  = state_q;
		term_d   = term_q;
		cnt_d    = cnt_q;
		chk_d    = chk_q;
		cmd      = '0;
		cmd.term = term_q;
		in_ready = 1'b0;
		unique case (state_q)
			pid_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					term_d   = pid_pkg::TERM_P;
					state_d  = stat.ts_zero ? pid_pkg::S_OPND : pid_pkg::S_LOAD_I;
				end
			end
			pid_pkg::S_LOAD_I: begin
				cmd.div_load_i = 1'b1;
				cnt_d          = '0;
				state_d        = pid_pkg::S_DIV_I;
			end
			pid_pkg::S_DIV_I: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ITERS - 1)) begin
					state_d = pid_pkg::S_INT;
				end
			end
			pid_pkg::S_INT: begin
				cmd.int_update = 1'b1;
				state_d        = pid_pkg::S_LOAD_D;
			end
			pid_pkg::S_LOAD_D: begin
				cmd.div_load_d = 1'b1;
				cnt_d          = '0;
				state_d        = pid_pkg::S_DIV_D;
			end
			pid_pkg::S_DIV_D: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ITERS - 1)) begin
					state_d = pid_pkg::S_DER;
				end
			end
			pid_pkg::S_DER: begin
				cmd.deriv_update = 1'b1;
				state_d          = pid_pkg::S_OPND;
			end
			pid_pkg::S_OPND: begin
				cmd.op_load = 1'b1;
				chk_d       = '0;
				state_d     = pid_pkg::S_MUL;
			end
			pid_pkg::S_MUL: begin
				cmd.mul       = 1'b1;
				cmd.top_chunk = (chk_q == '0);
				state_d       = pid_pkg::S_ACC;
			end
			pid_pkg::S_ACC: begin
				cmd.acc_add = 1'b1;
				if (chk_q == CHK_W'(NCH - 1)) begin
					state_d = pid_pkg::S_FOLD;
				end else begin
					chk_d   = chk_q + 1'b1;
					state_d = pid_pkg::S_MUL;
				end
			end
			pid_pkg::S_FOLD: begin
				cmd.fold = 1'b1;
				if (term_q == pid_pkg::TERM_D) begin
					state_d = pid_pkg::S_DONE;
				end else begin
					term_d  = term_next;
					state_d = pid_pkg::S_OPND;
				end
			end
			pid_pkg::S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = pid_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pid_pkg::S_IDLE;
			end
		endcase
	end

	// State and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pid_pkg::S_IDLE;
			term_q  <= pid_pkg::TERM_P;
			cnt_q   <= '0;
			chk_q   <= '0;
		end else begin
			state_q <= state_d;
			term_q  <= term_d;
			cnt_q   <= cnt_d;
			chk_q   <= chk_d;
		end
	end

endmodule

// ===== src/pid_dp.sv =====
// Datapath for the PID controller step: configuration registers, error state,
// shared two-bit-per-cycle divider, chunked gain multiply-accumulate and output register.
// Depends on pid_pkg for widths, register indexes and the command and status types.
module pid_dp #(
	parameter int SAMPLE_BITS = pid_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = pid_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pid_pkg::pid_cmd_t                    cmd,
	output pid_pkg::pid_stat_t                   stat,
	input  logic [SAMPLE_BITS-1:0]               sample,
	input  logic                                 cfg_valid,
	input  logic [pid_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [pid_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic signed [pid_pkg::DRIVE_W-1:0]   drive,
	output logic signed [SAMPLE_BITS:0]          error_now,
	output logic                                 saturated
);

	localparam int GW    = pid_pkg::GAIN_W;
	localparam int TSW   = pid_pkg::STEP_W;
	localparam int DENW  = pid_pkg::DEN_W;
	localparam int IW    = pid_pkg::INTEG_W;
	localparam int DW    = pid_pkg::DRIVE_W;
	localparam int CH    = pid_pkg::CHUNK_W;
	localparam int NB    = 2 * pid_pkg::div_iters(SAMPLE_BITS, FRAC_BITS);
	localparam int XW    = pid_pkg::opnd_bits(SAMPLE_BITS, FRAC_BITS);
	localparam int OPW   = pid_pkg::chunk_count(SAMPLE_BITS, FRAC_BITS) * CH;
	localparam int SUMW  = XW + 1;
	localparam int ACCW  = OPW + GW;
	localparam int TOTW  = ACCW - FRAC_BITS + 2;
	localparam int EW    = SAMPLE_BITS + 1;
	localparam int DEW   = SAMPLE_BITS + 2;

	localparam logic signed [SUMW-1:0] INT_MAX =
		$signed({{(SUMW-IW+1){1'b0}}, {(IW-1){1'b1}}});
	localparam logic signed [SUMW-1:0] INT_MIN =
		$signed({{(SUMW-IW+1){1'b1}}, {(IW-1){1'b0}}});
	localparam logic signed [TOTW-1:0] DRV_MAX =
		$signed({{(TOTW-DW+1){1'b0}}, {(DW-1){1'b1}}});
	localparam logic signed [TOTW-1:0] DRV_MIN =
		$signed({{(TOTW-DW+1){1'b1}}, {(DW-1){1'b0}}});

	// Configuration registers.
	logic [SAMPLE_BITS-1:0]   reference_q;
	logic signed [GW-1:0]     gain_p_q, gain_i_q, gain_d_q;
	logic [TSW-1:0]           time_step_q;
	logic                     time_unit_q;

	// Controller state.
	logic signed [EW-1:0]     last_error_q;
	logic signed [IW-1:0]     integ_q;

	// Per-item working registers.
	logic signed [EW-1:0]     e_q;
	logic signed [DEW-1:0]    de_q;
	logic signed [XW-1:0]     deriv_q;
	logic                     clip_q;
	logic [NB-1:0]            div_num_q;
	logic [DENW-1:0]          div_rem_q;
	logic [DENW-1:0]          div_den_q;
	logic signed [OPW-1:0]    opnd_q;
	logic signed [GW-1:0]     gsel_q;
	logic signed [GW+CH:0]    prod_q;
	logic signed [ACCW-1:0]   term_acc_q;
	logic signed [TOTW-1:0]   total_q;

	// Output register.
	logic                     out_valid_q;
	logic signed [DW-1:0]     drive_q;
	logic signed [EW-1:0]     err_out_q;
	logic                     sat_q;

	// Combinational helpers.
	logic signed [EW-1:0]     e_new;
	logic signed [DEW-1:0]    de_new;
	logic [SAMPLE_BITS-1:0]   mag_e;
	logic [SAMPLE_BITS:0]     mag_de;
	logic [DENW-1:0]          div_const;
	logic [SAMPLE_BITS+TSW-1:0]  prod_et;
	logic [SAMPLE_BITS+DENW:0]   prod_dd;
	logic [DENW:0]            r1, r2;
	logic                     ge1, ge2;
	logic [DENW-1:0]          rem1, rem2;
	logic signed [SUMW-1:0]   q_ext, int_sum;
	logic signed [IW-1:0]     int_sat;
	logic                     int_clip;
	logic signed [XW-1:0]     q_x;
	logic signed [OPW-1:0]    x_sel;
	logic signed [GW-1:0]     g_sel;
	logic [CH-1:0]            chunk;
	logic signed [CH:0]       chunk_op;
	logic signed [DW-1:0]     drv_sat;
	logic                     drv_clip;

	// Error and error change for a new sample.
	assign e_new  = $signed({1'b0, reference_q}) - $signed({1'b0, sample});
	assign de_new = DEW'(e_new) - DEW'(last_error_q);

	// Magnitudes of the latched error and error change.
	assign mag_e  = e_q[EW-1] ? SAMPLE_BITS'(-e_q) : SAMPLE_BITS'(e_q);
	assign mag_de = de_q[DEW-1] ? (SAMPLE_BITS+1)'(-de_q) : (SAMPLE_BITS+1)'(de_q);

	// Time-unit divisor and the two dividend products.
	assign div_const = time_unit_q ? DENW'(pid_pkg::DIV_OTHER) : DENW'(pid_pkg::DIV_MS);
	assign prod_et   = mag_e * time_step_q;
	assign prod_dd   = mag_de * div_const;

	// Two restoring divider steps per cycle.
	always_comb begin
		r1   = {div_rem_q, div_num_q[NB-1]};
		ge1  = (r1 >= {1'b0, div_den_q});
		rem1 = ge1 ? DENW'(r1 - {1'b0, div_den_q}) : DENW'(r1);
		r2   = {rem1, div_num_q[NB-2]};
		ge2  = (r2 >= {1'b0, div_den_q});
		rem2 = ge2 ? DENW'(r2 - {1'b0, div_den_q}) : DENW'(r2);
	end

	// Integral update with saturation to the state width.
	always_comb begin
		q_ext   = $signed(SUMW'(div_num_q));
		int_sum = SUMW'(integ_q) + (e_q[EW-1] ? -q_ext : q_ext);
		if (int_sum > INT_MAX) begin
			int_sat  = IW'(INT_MAX);
			int_clip = 1'b1;
		end else if (int_sum < INT_MIN) begin
			int_sat  = IW'(INT_MIN);
			int_clip = 1'b1;
		end else begin
			int_sat  = IW'(int_sum);
			int_clip = 1'b0;
		end
	end

	// Signed derivative from the quotient.
	assign q_x = $signed(XW'(div_num_q));

	// Operand and gain for the selected term.
	always_comb begin
		unique case (cmd.term)
			pid_pkg::TERM_P: begin
				x_sel = OPW'(e_q) <<< FRAC_BITS;
				g_sel = gain_p_q;
			end
			pid_pkg::TERM_I: begin
				x_sel = OPW'(integ_q);
				g_sel = gain_i_q;
			end
			pid_pkg::TERM_D: begin
				x_sel = OPW'(deriv_q);
				g_sel = gain_d_q;
			end
			default: begin
				x_sel = '0;
				g_sel = '0;
			end
		endcase
	end

	// Top chunk of the operand is signed, the rest unsigned.
	assign chunk    = opnd_q[OPW-1 -: CH];
	assign chunk_op = $signed({cmd.top_chunk & chunk[CH-1], chunk});

	// Output saturation to 32 bits.
	always_comb begin
		if (total_q > DRV_MAX) begin
			drv_sat  = DW'(DRV_MAX);
			drv_clip = 1'b1;
		end else if (total_q < DRV_MIN) begin
			drv_sat  = DW'(DRV_MIN);
			drv_clip = 1'b1;
		end else begin
			drv_sat  = DW'(total_q);
			drv_clip = 1'b0;
		end
	end

	// Configuration, controller state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reference_q  <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
			gain_p_q     <= pid_pkg::GAIN_P_RESET;
			gain_i_q     <= '0;
			gain_d_q     <= '0;
			time_step_q  <= pid_pkg::STEP_RESET;
			time_unit_q  <= 1'b0;
			last_error_q <= '0;
			integ_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					pid_pkg::REG_REFERENCE: reference_q <= cfg_data[SAMPLE_BITS-1:0];
					pid_pkg::REG_GAIN_P:    gain_p_q    <= $signed(cfg_data[GW-1:0]);
					pid_pkg::REG_GAIN_I:    gain_i_q    <= $signed(cfg_data[GW-1:0]);
					pid_pkg::REG_GAIN_D:    gain_d_q    <= $signed(cfg_data[GW-1:0]);
					pid_pkg::REG_TIME_STEP: time_step_q <= cfg_data[TSW-1:0];
					pid_pkg::REG_TIME_UNIT: time_unit_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.take) begin
				last_error_q <= e_new;
			end
			if (cmd.int_update) begin
				integ_q <= int_sat;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working and payload registers.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			e_q     <= e_new;
			de_q    <= de_new;
			deriv_q <= '0;
			clip_q  <= 1'b0;
			total_q <= '0;
		end
		if (cmd.div_load_i) begin
			div_num_q <= NB'({prod_et, {FRAC_BITS{1'b0}}}) + NB'(div_const[DENW-1:1]);
			div_den_q <= div_const;
			div_rem_q <= '0;
		end
		if (cmd.div_load_d) begin
			div_num_q <= NB'({prod_dd, {FRAC_BITS{1'b0}}}) + NB'(time_step_q[TSW-1:1]);
			div_den_q <= DENW'(time_step_q);
			div_rem_q <= '0;
		end
		if (cmd.div_step) begin
			div_num_q <= {div_num_q[NB-3:0], ge1, ge2};
			div_rem_q <= rem2;
		end
		if (cmd.int_update) begin
			clip_q <= int_clip;
		end
		if (cmd.deriv_update) begin
			deriv_q <= de_q[DEW-1] ? -q_x : q_x;
		end
		if (cmd.op_load) begin
			opnd_q     <= x_sel;
			gsel_q     <= g_sel;
			term_acc_q <= '0;
		end
		if (cmd.mul) begin
			prod_q <= gsel_q * chunk_op;
			opnd_q <= opnd_q <<< CH;
		end
		if (cmd.acc_add) begin
			term_acc_q <= (term_acc_q <<< CH) + ACCW'(prod_q);
		end
		if (cmd.fold) begin
			total_q <= total_q + TOTW'(term_acc_q >>> FRAC_BITS);
		end
		if (cmd.out_load) begin
			drive_q   <= drv_sat;
			err_out_q <= e_q;
			sat_q     <= clip_q | drv_clip;
		end
	end

	assign stat.ts_zero  = (time_step_q == '0);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign error_now = err_out_q;
	assign saturated = sat_q;

endmodule

// ===== src/pid_controller_step.sv =====
// Discrete PID controller, one control step per input beat.
// Channels: s_* carries the sample beat in; m_* carries the result beat out
// (drive in Q16.16 with error_now in tdata, the clip flag in tuser).
// cfg_* writes one register per beat by index: 0 reference, 1 gain_p, 2 gain_i,
// 3 gain_d, 4 time_step, 5 time_unit; cfg_ready is always high. Write registers
// only while no step is in flight.
// Sequence: a step runs ITERS = (SAMPLE_BITS + FRAC_BITS + 20) / 2 two-bit divider
// steps, once for the integral increment and once for the derivative, then works the
// three gain terms in the shared 24 x 25 gain multiplier. With time_step zero the
// divides are skipped. One step is worked at a time; s_tready is high only while the
// sequencer waits for a sample, so a new sample is not taken before the last step
// has loaded its result.
// The finished result sits in an output register, so the next sample is taken while
// it waits; if the receiver stalls, the following step holds in its last state
// until that register is free.
// Reset clears the error history and integral and restores the register defaults.
// Depends on pid_pkg, pid_ctrl and pid_dp.
module pid_controller_step #(
	parameter int SAMPLE_BITS = pid_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = pid_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// Fields from bit 0: sample, then zero fill.
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// Fields from bit 0: drive (32), error_now (SAMPLE_BITS+1), then zero fill.
	output logic [((SAMPLE_BITS+40)/8)*8-1:0]    m_tdata,
	// Fields from bit 0: saturated.
	output logic                                 m_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pid_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [pid_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int OUT_W = ((SAMPLE_BITS + 40) / 8) * 8;

	pid_pkg::pid_cmd_t  cmd;
	pid_pkg::pid_stat_t stat;

	logic signed [pid_pkg::DRIVE_W-1:0] drive;
	logic signed [SAMPLE_BITS:0]        error_now;
	logic                               saturated;

	// Sequencer.
	pid_ctrl #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Arithmetic, state and output register.
	pid_dp #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.sample    (s_tdata[SAMPLE_BITS-1:0]),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.drive     (drive),
		.error_now (error_now),
		.saturated (saturated)
	);

	// Pack the result beat.
	assign m_tdata   = OUT_W'({error_now, drive});
	assign m_tuser   = saturated;
	assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
	// A taken sample keeps the block busy on the next cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after a sample beat");

	// A result is loaded only when the output register can take it.
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result loaded over a pending output beat");

	// A result beat appears only right after a load.
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.out_load))
		else $error("output valid rose without a result load");

	// The sequencer issues at most one datapath action per cycle.
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.div_load_i, cmd.div_load_d, cmd.div_step,
			cmd.int_update, cmd.deriv_update, cmd.op_load, cmd.mul,
			cmd.acc_add, cmd.fold, cmd.out_load}))
		else $error("more than one datapath action in a cycle");
`endif

endmodule

// ===== test/pid_controller_step_test.sv =====
// Self-checking testbench for pid_controller_step: a directed table, then random phases.
// Each result beat is checked against a bit-exact PID step predictor kept in this file.
// Depends on pid_pkg and the pid_controller_step RTL.
module pid_controller_step_test;

	localparam int SBITS    = pid_pkg::SAMPLE_BITS_DEF;
	localparam int FBITS    = pid_pkg::FRAC_BITS_DEF;
	localparam int S_W      = ((SBITS + 7) / 8) * 8;
	localparam int M_W      = ((SBITS + 40) / 8) * 8;
	localparam int RANDOM_SAMPLES = 1330;
	localparam int SETTLE_CYCLES  = 200;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int REPORT_LINES   = 40;

	// Indexes past the register list; writes to them must change nothing.
	localparam logic [pid_pkg::CFG_INDEX_W-1:0] REG_UNUSED_A = 3'd6;
	localparam logic [pid_pkg::CFG_INDEX_W-1:0] REG_UNUSED_B = 3'd7;

	localparam longint DRIVE_MAX = (longint'(1) << 31) - 1;
	localparam longint DRIVE_MIN = -DRIVE_MAX - 1;
	localparam longint INTEG_MAX = (longint'(1) << 47) - 1;
	localparam longint INTEG_MIN = -INTEG_MAX - 1;

	typedef struct packed {
		logic signed [pid_pkg::DRIVE_W-1:0] drive;
		logic signed [SBITS:0]              err;
		logic                               sat;
	} pid_result_t;

	// One row of the directed table: a register write or a sample beat.
	typedef struct {
		logic                            is_write;
		logic [pid_pkg::CFG_INDEX_W-1:0] idx;
		logic [pid_pkg::CFG_DATA_W-1:0]  wdata;
		logic [SBITS-1:0]                smp;
		logic                            typed;
		pid_result_t                     want;
	} plan_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [S_W-1:0]                  s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [M_W-1:0]                  m_tdata;
	logic                            m_tuser;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [pid_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [pid_pkg::CFG_DATA_W-1:0]  cfg_data;

	// Predictor copy of the registers and the controller state.
	logic [SBITS-1:0]                  p_ref;
	logic signed [pid_pkg::GAIN_W-1:0] p_kp;
	logic signed [pid_pkg::GAIN_W-1:0] p_ki;
	logic signed [pid_pkg::GAIN_W-1:0] p_kd;
	logic [pid_pkg::STEP_W-1:0]        p_step;
	logic                              p_unit;
	longint                            p_last_err;
	longint                            p_integ;

	pid_result_t step_results[$];
	plan_row_t   plan[$];

	logic   eager;
	int     cycle_count;
	int     mismatch_count;
	int     samples_sent;
	int     writes_done;
	int     results_seen;
	int     clip_seen;
	int     zero_step_phases;

	pid_controller_step u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles", cycle_count);
		$display("Regression FAIL");
		$finish;
	end

	// Rounded division, ties away from zero, with the sign applied afterward.
	function automatic longint round_div(input logic neg, input longint unsigned mag,
			input longint unsigned den);
		longint unsigned q;
		q = (mag + den / 2) / den;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	// floor(gain * x / 2^FBITS) without overflow: split x into whole and fraction parts.
	function automatic longint gain_scale(input logic signed [pid_pkg::GAIN_W-1:0] g,
			input longint x);
		longint whole;
		longint frac;
		whole = x >>> FBITS;
		frac  = longint'(x[FBITS-1:0]);
		return longint'(g) * whole + ((longint'(g) * frac) >>> FBITS);
	endfunction

	// One control step: updates integral and error history, returns the result beat.
	function automatic pid_result_t pid_step_predict(input logic [SBITS-1:0] smp);
		longint          err;
		longint          derr;
		longint          acc;
		longint          deriv;
		longint          sum;
		longint unsigned den;
		longint unsigned mag;
		logic            clip;
		pid_result_t     r;
		err   = longint'(p_ref) - longint'(smp);
		den   = p_unit ? pid_pkg::DIV_OTHER : pid_pkg::DIV_MS;
		clip  = 1'b0;
		deriv = 0;
		if (p_step != 0) begin
			derr = err - p_last_err;
			mag  = (err < 0) ? -err : err;
			acc  = p_integ + round_div(err < 0, (mag * p_step) << FBITS, den);
			if (acc > INTEG_MAX) begin
				acc  = INTEG_MAX;
				clip = 1'b1;
			end
			if (acc < INTEG_MIN) begin
				acc  = INTEG_MIN;
				clip = 1'b1;
			end
			p_integ = acc;
			mag     = (derr < 0) ? -derr : derr;
			deriv   = round_div(derr < 0, (mag * den) << FBITS, p_step);
		end
		p_last_err = err;
		sum = longint'(p_kp) * err + gain_scale(p_ki, p_integ);
		if (p_step != 0)
			sum += gain_scale(p_kd, deriv);
		if (sum > DRIVE_MAX) begin
			sum  = DRIVE_MAX;
			clip = 1'b1;
		end
		if (sum < DRIVE_MIN) begin
			sum  = DRIVE_MIN;
			clip = 1'b1;
		end
		r.drive = sum[pid_pkg::DRIVE_W-1:0];
		r.err   = err[SBITS:0];
		r.sat   = clip;
		return r;
	endfunction

	function automatic int draw_wait();
		return eager ? 0 : int'($urandom_range(0, 11));
	endfunction

	// Gains: mostly moderate magnitudes so that outputs are not always clipped.
	function automatic logic [pid_pkg::CFG_DATA_W-1:0] pick_gain();
		int k;
		case ($urandom_range(0, 5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return '0;
			default: begin
				k = $urandom_range(0, 20);
				return pid_pkg::CFG_DATA_W'($urandom_range(0, (1 << (k + 1)) - 1) - (1 << k));
			end
		endcase
	endfunction

	function automatic plan_row_t wr_row(input logic [pid_pkg::CFG_INDEX_W-1:0] idx,
			input logic [pid_pkg::CFG_DATA_W-1:0] v);
		plan_row_t r;
		r.is_write = 1'b1;
		r.idx      = idx;
		r.wdata    = v;
		r.smp      = '0;
		r.typed    = 1'b0;
		r.want     = '0;
		return r;
	endfunction

	function automatic plan_row_t smp_row(input logic [SBITS-1:0] s, input logic typed,
			input longint drv, input int err, input logic sat);
		plan_row_t r;
		r.is_write   = 1'b0;
		r.idx        = '0;
		r.wdata      = '0;
		r.smp        = s;
		r.typed      = typed;
		r.want.drive = drv[pid_pkg::DRIVE_W-1:0];
		r.want.err   = err[SBITS:0];
		r.want.sat   = sat;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		if (mismatch_count <= REPORT_LINES)
			$display("cycle %0d: %s mismatch, got %0d, expected %0d", cycle_count, what, got,
				want);
	endtask

	// Register write beat; the predictor takes the same masking as the block.
	task automatic write_reg(input logic [pid_pkg::CFG_INDEX_W-1:0] idx,
			input logic [pid_pkg::CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			pid_pkg::REG_REFERENCE: p_ref  = v[SBITS-1:0];
			pid_pkg::REG_GAIN_P:    p_kp   = v;
			pid_pkg::REG_GAIN_I:    p_ki   = v;
			pid_pkg::REG_GAIN_D:    p_kd   = v;
			pid_pkg::REG_TIME_STEP: p_step = v[pid_pkg::STEP_W-1:0];
			pid_pkg::REG_TIME_UNIT: p_unit = v[0];
			default: ;
		endcase
		writes_done++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Sample beat after a random gap; the expectation is queued at acceptance.
	task automatic drive_sample(input logic [SBITS-1:0] smp, input logic typed,
			input pid_result_t typed_want);
		int          gap;
		pid_result_t pred;
		gap = draw_wait();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = S_W'(smp);
		do @(posedge clk); while (!s_tready);
		pred = pid_step_predict(smp);
		step_results.push_back(typed ? typed_want : pred);
		samples_sent++;
	endtask

	// Stop sending and wait until every step has delivered its result.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (step_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_result(input logic [M_W-1:0] data, input logic user);
		pid_result_t want;
		if (step_results.size() == 0) begin
			report_mismatch("unexpected beat drive", signed'(data[pid_pkg::DRIVE_W-1:0]), 0);
			return;
		end
		want = step_results.pop_front();
		results_seen++;
		if (user === 1'b1)
			clip_seen++;
		if (data[pid_pkg::DRIVE_W-1:0] !== want.drive)
			report_mismatch("drive", signed'(data[pid_pkg::DRIVE_W-1:0]), want.drive);
		if (data[pid_pkg::DRIVE_W+SBITS:pid_pkg::DRIVE_W] !== want.err)
			report_mismatch("error_now",
				signed'(data[pid_pkg::DRIVE_W+SBITS:pid_pkg::DRIVE_W]), want.err);
		if (user !== want.sat)
			report_mismatch("saturated", user, want.sat);
	endtask

	// Receiver: stalls a random number of cycles before each beat.
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait();
			@(negedge clk);
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			check_result(m_tdata, m_tuser);
		end
	end

	// Stimulus: reset, directed table, then random phases.
	initial begin
		int                         count;
		int                         k;
		logic                       walk;
		logic [SBITS-1:0]           smp;
		logic [SBITS-1:0]           ref_v;
		logic [pid_pkg::STEP_W-1:0] step_v;
		arst_n           = 1'b0;
		s_tvalid         = 1'b0;
		s_tdata          = '0;
		cfg_valid        = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		eager            = 1'b0;
		mismatch_count   = 0;
		samples_sent     = 0;
		writes_done      = 0;
		results_seen     = 0;
		clip_seen        = 0;
		zero_step_phases = 0;
		p_ref            = 10'd512;
		p_kp             = pid_pkg::GAIN_P_RESET;
		p_ki             = '0;
		p_kd             = '0;
		p_step           = pid_pkg::STEP_RESET;
		p_unit           = 1'b0;
		p_last_err       = 0;
		p_integ          = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Defaults after reset: pure unit proportional gain; first step sees no history.
		plan.push_back(smp_row(10'd0,    1'b1, 33554432, 512, 1'b0));
		plan.push_back(smp_row(10'd1023, 1'b1, -33488896, -511, 1'b0));
		plan.push_back(smp_row(10'd512,  1'b1, 0, 0, 1'b0));
		// Extreme proportional gains clip the drive both ways.
		plan.push_back(wr_row(pid_pkg::REG_GAIN_P, 24'h7FFFFF));
		plan.push_back(smp_row(10'd0,    1'b1, DRIVE_MAX, 512, 1'b1));
		plan.push_back(smp_row(10'd1023, 1'b1, DRIVE_MIN, -511, 1'b1));
		plan.push_back(wr_row(pid_pkg::REG_GAIN_P, 24'h800000));
		plan.push_back(smp_row(10'd1023, 1'b1, DRIVE_MAX, -511, 1'b1));
		plan.push_back(smp_row(10'd0,    1'b1, DRIVE_MIN, 512, 1'b1));
		// Reference at both ends, upper data bits masked off.
		plan.push_back(wr_row(pid_pkg::REG_REFERENCE, 24'hFFFFFF));
		plan.push_back(wr_row(pid_pkg::REG_GAIN_P, 24'h010000));
		plan.push_back(smp_row(10'd0,    1'b1, 67043328, 1023, 1'b0));
		plan.push_back(smp_row(10'd1023, 1'b1, 0, 0, 1'b0));
		plan.push_back(wr_row(pid_pkg::REG_REFERENCE, 24'hFFFC00));
		plan.push_back(smp_row(10'd1023, 1'b1, -67043328, -1023, 1'b0));
		// All three terms active, finest time unit, shortest step.
		plan.push_back(wr_row(pid_pkg::REG_GAIN_I, 24'h010000));
		plan.push_back(wr_row(pid_pkg::REG_GAIN_D, 24'h000100));
		plan.push_back(wr_row(pid_pkg::REG_TIME_STEP, 24'hFF0001));
		plan.push_back(wr_row(pid_pkg::REG_TIME_UNIT, 24'hFFFFFF));
		plan.push_back(wr_row(pid_pkg::REG_REFERENCE, 24'd300));
		plan.push_back(smp_row(10'd100, 1'b0, 0, 0, 1'b0));
		plan.push_back(smp_row(10'd900, 1'b0, 0, 0, 1'b0));
		plan.push_back(smp_row(10'd900, 1'b0, 0, 0, 1'b0));
		plan.push_back(smp_row(10'd3,   1'b0, 0, 0, 1'b0));
		// Zero time step: integral frozen and no derivative term.
		plan.push_back(wr_row(pid_pkg::REG_TIME_STEP, 24'h000000));
		plan.push_back(smp_row(10'd0,    1'b0, 0, 0, 1'b0));
		plan.push_back(smp_row(10'd1023, 1'b0, 0, 0, 1'b0));
		plan.push_back(smp_row(10'd512,  1'b0, 0, 0, 1'b0));
		// Writes past the register list are ignored.
		plan.push_back(wr_row(REG_UNUSED_A, 24'hFFFFFF));
		plan.push_back(wr_row(REG_UNUSED_B, 24'h000000));
		plan.push_back(smp_row(10'd300, 1'b0, 0, 0, 1'b0));
		// Longest step in milliseconds, extreme integral and derivative gains.
		plan.push_back(wr_row(pid_pkg::REG_TIME_STEP, 24'h00FFFF));
		plan.push_back(wr_row(pid_pkg::REG_TIME_UNIT, 24'h000000));
		plan.push_back(wr_row(pid_pkg::REG_GAIN_D, 24'h800000));
		plan.push_back(wr_row(pid_pkg::REG_GAIN_I, 24'h7FFFFF));
		plan.push_back(smp_row(10'd1023, 1'b0, 0, 0, 1'b0));
		plan.push_back(smp_row(10'd0,    1'b0, 0, 0, 1'b0));

		foreach (plan[i]) begin
			if (plan[i].is_write) begin
				drain_results();
				write_reg(plan[i].idx, plan[i].wdata);
			end else begin
				drive_sample(plan[i].smp, plan[i].typed, plan[i].want);
			end
		end
		count = samples_sent;

		// Random phases: fresh settings, then a run of samples with its own pacing.
		smp = 10'd512;
		while (samples_sent < count + RANDOM_SAMPLES) begin
			drain_results();
			eager = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 3))
					0: ref_v = '0;
					1: ref_v = '1;
					default: ref_v = SBITS'($urandom);
				endcase
				write_reg(pid_pkg::REG_REFERENCE,
					{(pid_pkg::CFG_DATA_W-SBITS)'($urandom), ref_v});
			end
			if ($urandom_range(0, 1))
				write_reg(pid_pkg::REG_GAIN_P, pick_gain());
			if ($urandom_range(0, 1))
				write_reg(pid_pkg::REG_GAIN_I, pick_gain());
			if ($urandom_range(0, 1))
				write_reg(pid_pkg::REG_GAIN_D, pick_gain());
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 9))
					0: step_v = '0;
					1: step_v = 16'd1;
					2: step_v = '1;
					3: step_v = pid_pkg::STEP_W'($urandom);
					default: step_v = pid_pkg::STEP_W'($urandom_range(100, 5000));
				endcase
				write_reg(pid_pkg::REG_TIME_STEP,
					{(pid_pkg::CFG_DATA_W-pid_pkg::STEP_W)'($urandom), step_v});
			end
			if ($urandom_range(0, 1))
				write_reg(pid_pkg::REG_TIME_UNIT, pid_pkg::CFG_DATA_W'($urandom));
			if ($urandom_range(0, 7) == 0)
				write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B,
					pid_pkg::CFG_DATA_W'($urandom));
			if (p_step == 0)
				zero_step_phases++;

			// Half the phases walk slowly so the derivative stays small.
			walk = $urandom_range(0, 1);
			repeat ($urandom_range(20, 80)) begin
				if ($urandom_range(0, 15) == 0) begin
					smp = $urandom_range(0, 1) ? '1 : '0;
				end else if (walk) begin
					k = int'(smp) + int'($urandom_range(0, 16)) - 8;
					smp = (k < 0) ? '0 : (k > (1 << SBITS) - 1) ? '1 : SBITS'(k);
				end else begin
					smp = SBITS'($urandom);
				end
				drive_sample(smp, 1'b0, '0);
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d samples (%0d from the directed table) with %0d register writes.",
			samples_sent, count, writes_done);
		$display("Checked %0d results, %0d of them clipped; %0d phases ran with a zero step.",
			results_seen, clip_seen, zero_step_phases);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
